// ===== design/pltd_pkg.sv =====
// Package for the point-light to directional converter.
// Holds field widths, the pipeline word type and the stage count.
`default_nettype none
package pltd_pkg;
  localparam int PosW   = 24;
  localparam int DiffW  = 25;
  localparam int AbsW   = 24;
  localparam int DistW  = 16;
  localparam int RadW   = 16;
  localparam int ColW   = 15;
  localparam int DirW   = 14;
  localparam int FracW  = 12;
  localparam int QuoW   = 17;
  localparam int DistFullW = 26;
  localparam int DivSteps = 17;
  localparam int DefaultStages = DivSteps;

  typedef struct packed {
    logic                    live;
    logic                    ok;
    logic signed [DistW:0]   dx;
    logic signed [DistW:0]   dy;
    logic signed [DistW:0]   dz;
    logic [DistW-1:0]        distance;
    logic [RadW-1:0]         radius;
    logic [ColW-1:0]         red;
    logic [ColW-1:0]         green;
    logic [ColW-1:0]         blue;
    logic [DistW+FracW:0]    rx;
    logic [DistW+FracW:0]    ry;
    logic [DistW+FracW:0]    rz;
    logic [DistW+FracW:0]    rf;
    logic [QuoW-1:0]         qx;
    logic [QuoW-1:0]         qy;
    logic [QuoW-1:0]         qz;
    logic [QuoW-1:0]         qf;
  } pltd_word_t;
endpackage
`default_nettype wire

// ===== design/point_light_to_directional_core.sv =====
// Top level: front end for distance, a row of division cells, and a scaling tail.
// Depends on pltd_pkg and pltd_cell.
//
// channel | dir | fields (low bit up)
// s_axis  | in  | obj_x obj_y obj_z lamp_x lamp_y lamp_z lamp_radius lamp_red lamp_green
//         |     | lamp_blue in tdata; lamp_enable in tuser
// m_axis  | out | dir_x dir_y dir_z lit_red lit_green lit_blue in tdata; in_range in tuser
//
// One word enters per cycle while the output is not stalled. The path runs through one
// front-end register, one cell per quotient bit, one multiply register and the output register.
// The whole row advances together; a stalled output freezes every stage and drops ready.
// Reset clears the valid bits only.
`default_nettype none
module point_light_to_directional_core
  import pltd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [207:0] s_axis_tdata,  // obj xyz, lamp xyz, radius, red, green, blue
  input  wire          s_axis_tuser,  // lamp_enable
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // dir_x dir_y dir_z lit_red lit_green lit_blue
  output logic         m_axis_tuser   // in_range
);
  localparam int Stages = DivSteps;
  localparam int RemW = DistW + FracW + 1;

  logic advance;
  pltd_word_t row [Stages+1];
  logic signed [DiffW-1:0] d [3];
  logic [AbsW-1:0] a [3];
  logic [AbsW-1:0] mx;
  logic [DistFullW-1:0] dist_full;
  logic [RadW-1:0] radius;
  pltd_word_t head;
  logic t_live, t_ok;
  logic [DirW-1:0] t_dx, t_dy, t_dz;
  logic [ColW+QuoW-1:0] t_r, t_g, t_b;

  // Hold everything while the output word waits.
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d[c] = DiffW'($signed(s_axis_tdata[(c+3)*PosW +: PosW]))
           - DiffW'($signed(s_axis_tdata[c*PosW +: PosW]));
      a[c] = AbsW'(d[c] < 0 ? -d[c] : d[c]);
    end
    mx = (a[0] > a[1]) ? ((a[0] > a[2]) ? a[0] : a[2]) : ((a[1] > a[2]) ? a[1] : a[2]);
    dist_full = DistFullW'(mx) + ((DistFullW'(a[0]) + DistFullW'(a[1]) + DistFullW'(a[2])
              - DistFullW'(mx)) >> 1);
    radius = s_axis_tdata[6*PosW +: RadW];
    head = '0;
    head.live     = s_axis_tvalid;
    head.ok       = s_axis_tuser && radius != '0 && dist_full != '0
                  && dist_full < DistFullW'(radius);
    head.dx       = d[0][DistW:0];
    head.dy       = d[1][DistW:0];
    head.dz       = d[2][DistW:0];
    head.distance = dist_full[DistW-1:0];
    head.radius   = radius;
    head.red      = s_axis_tdata[6*PosW+RadW +: ColW];
    head.green    = s_axis_tdata[6*PosW+RadW+ColW +: ColW];
    head.blue     = s_axis_tdata[6*PosW+RadW+2*ColW +: ColW];
    // Seed each remainder with the numerator bits above the ones the cells retire;
    // every quotient stays below 2^Stages, so those bits alone are below the divisor.
    head.rx       = RemW'(a[0] >> (Stages - FracW));
    head.ry       = RemW'(a[1] >> (Stages - FracW));
    head.rz       = RemW'(a[2] >> (Stages - FracW));
    head.rf       = RemW'((radius - head.distance) >> (Stages - FracW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].live <= 1'b0;
    end else if (advance) begin
      row[0] <= head;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    pltd_cell #(.Bit(Stages-1-i)) u_cell (
      .clk(clk), .rst(rst), .advance(advance), .word_in(row[i]), .word_out(row[i+1]));
  end

  // Apply signs and scale color by the falloff.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_live <= 1'b0;
    end else if (advance) begin
      t_live <= row[Stages].live;
      t_ok <= row[Stages].ok;
      t_dx <= DirW'(row[Stages].dx < 0 ? -row[Stages].qx : row[Stages].qx);
      t_dy <= DirW'(row[Stages].dy < 0 ? -row[Stages].qy : row[Stages].qy);
      t_dz <= DirW'(row[Stages].dz < 0 ? -row[Stages].qz : row[Stages].qz);
      t_r <= (ColW+QuoW)'(row[Stages].red) * (ColW+QuoW)'(row[Stages].qf);
      t_g <= (ColW+QuoW)'(row[Stages].green) * (ColW+QuoW)'(row[Stages].qf);
      t_b <= (ColW+QuoW)'(row[Stages].blue) * (ColW+QuoW)'(row[Stages].qf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= t_live;
      m_axis_tuser  <= t_ok;
      m_axis_tdata  <= t_ok ? {1'b0, t_b[FracW +: ColW], t_g[FracW +: ColW],
                               t_r[FracW +: ColW], t_dz, t_dy, t_dx} : '0;
    end
  end
endmodule
`default_nettype wire

// ===== design/pltd_cell.sv =====
// One restoring-division cell: retires one quotient bit of four divisions.
// Depends on pltd_pkg for the pipeline word type.
`default_nettype none
module pltd_cell
  import pltd_pkg::*;
#(
  parameter int Bit = 0
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        advance,
  input  pltd_word_t word_in,
  output pltd_word_t word_out
);
  localparam int RW = DistW + FracW + 1;
  pltd_word_t w;

  function automatic logic [RW+QuoW-1:0] div_step(
      input logic [RW-1:0] rem, input logic [QuoW-1:0] q,
      input logic [DistW-1:0] dv, input logic [QuoW-1:0] num);
    logic [RW-1:0] t;
    logic [RW-1:0] sub;
    t = {rem[RW-2:0], num[Bit]};
    sub = RW'(dv);
    div_step = (t >= sub) ? {t - sub, q | (QuoW'(1) << Bit)} : {t, q};
  endfunction

  // The numerator's low bits are fed here; its high bits seed the remainder at the head.
  always_comb begin
    w = word_in;
    {w.rx, w.qx} = div_step(word_in.rx, word_in.qx, word_in.distance,
                            QuoW'(word_in.dx < 0 ? -word_in.dx : word_in.dx) << FracW);
    {w.ry, w.qy} = div_step(word_in.ry, word_in.qy, word_in.distance,
                            QuoW'(word_in.dy < 0 ? -word_in.dy : word_in.dy) << FracW);
    {w.rz, w.qz} = div_step(word_in.rz, word_in.qz, word_in.distance,
                            QuoW'(word_in.dz < 0 ? -word_in.dz : word_in.dz) << FracW);
    {w.rf, w.qf} = div_step(word_in.rf, word_in.qf, word_in.radius,
                            QuoW'(word_in.radius - word_in.distance) << FracW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.live <= 1'b0;
    end else if (advance) begin
      word_out <= w;
    end
  end
endmodule
`default_nettype wire

// ===== design/pltd_checker.sv =====
// Port-level checks for point_light_to_directional_core, bound to the top level.
// Imports pltd_pkg; its port widths are written as literals.
`default_nettype none
module pltd_checker
  import pltd_pkg::*;
(
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [87:0]  m_axis_tdata,
  input wire         m_axis_tuser
);
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected pair has nonzero fields");
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind point_light_to_directional_core pltd_checker u_pltd_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));
`default_nettype wire
